/* sv/kvr_pkg.sv */
// shared types, constants and register codes for the kv setpoint ramp controller
package kvr_pkg;

  localparam int VALUE_WIDTH = 15;
  localparam int KV_WIDTH = 14;
  localparam int STEP_WIDTH = 12;
  localparam int CFG_INDEX_WIDTH = 8;
  localparam int CFG_DATA_WIDTH = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_KV = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_KV = CFG_INDEX_WIDTH'(1);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FAST_STEP = CFG_INDEX_WIDTH'(2);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SLOW_STEP = CFG_INDEX_WIDTH'(3);

  localparam logic [KV_WIDTH-1:0] MIN_KV_RESET = KV_WIDTH'(400);
  localparam logic [KV_WIDTH-1:0] MAX_KV_RESET = KV_WIDTH'(10100);
  localparam logic [STEP_WIDTH-1:0] FAST_STEP_RESET = STEP_WIDTH'(100);
  localparam logic [STEP_WIDTH-1:0] SLOW_STEP_RESET = STEP_WIDTH'(50);

  localparam logic OP_SET = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [KV_WIDTH-1:0] min_kv;
    logic [KV_WIDTH-1:0] max_kv;
    logic [STEP_WIDTH-1:0] fast_step;
    logic [STEP_WIDTH-1:0] slow_step;
  } kvr_cfg_t;

  // drive and target hold two's complement values
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] drive;
    logic [VALUE_WIDTH-1:0] target;
    logic ramp;
    logic [1:0] stable_count;
  } kvr_state_t;

  typedef struct packed {
    logic op;
    logic hv_enabled;
    logic [VALUE_WIDTH-1:0] setpoint;
    logic [KV_WIDTH-1:0] feedback;
  } kvr_item_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] drive;
    logic ramping;
    logic aborted;
  } kvr_result_t;

endpackage

/* sv/kvr_cfg_regs.sv */
// configuration register file: min/max kv limits and ramp step sizes
module kvr_cfg_regs (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  input  logic [kvr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [kvr_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
  output kvr_pkg::kvr_cfg_t cfg
);
  import kvr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_kv <= MIN_KV_RESET;
      cfg.max_kv <= MAX_KV_RESET;
      cfg.fast_step <= FAST_STEP_RESET;
      cfg.slow_step <= SLOW_STEP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_KV: cfg.min_kv <= cfg_data[KV_WIDTH-1:0];
        REG_MAX_KV: cfg.max_kv <= cfg_data[KV_WIDTH-1:0];
        REG_FAST_STEP: cfg.fast_step <= cfg_data[STEP_WIDTH-1:0];
        REG_SLOW_STEP: cfg.slow_step <= cfg_data[STEP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/kvr_step.sv */
// next-state and result logic for one set or tick transaction
module kvr_step (
  input  kvr_pkg::kvr_cfg_t cfg,
  input  kvr_pkg::kvr_state_t st,
  input  kvr_pkg::kvr_item_t item,
  output kvr_pkg::kvr_state_t st_next,
  output kvr_pkg::kvr_result_t res
);
  import kvr_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int EW = ((VW > KV_WIDTH) ? VW : KV_WIDTH) + 2;
  localparam int PW = VW + 5;
  // floor(x/10) for x below 2^(VW+3): reciprocal estimate is low by at most one
  localparam int DS = VW + 4;
  localparam int DM = (2 ** DS) / 10;
  localparam int FS = STEP_WIDTH + 3;
  localparam int FM = (2 ** FS) / 5;

  localparam logic signed [EW-1:0] VMAX = EW'((2 ** (VW - 1)) - 1);
  localparam logic signed [EW-1:0] VMIN = -VMAX - EW'(1);
  localparam logic signed [EW-1:0] ERR_STABLE = EW'(100);
  localparam logic signed [EW-1:0] ERR_DROP = EW'(250);
  localparam logic signed [EW-1:0] ERR_FINE = EW'(10);
  localparam logic signed [EW-1:0] ERR_FAST = EW'(500);
  localparam logic signed [PW-1:0] NINE = PW'(9);
  localparam logic signed [PW-1:0] TEN = PW'(10);
  localparam logic signed [PW-1:0] ELEVEN = PW'(11);

  function automatic logic [VW-1:0] sat_value(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] c;
    c = v;
    if (v > VMAX) c = VMAX;
    if (v < VMIN) c = VMIN;
    return c[VW-1:0];
  endfunction

  logic signed [EW-1:0] drive_e, target_e, fb_e, min_e, max_e, err;
  logic signed [EW-1:0] slow_e, fast_e, fifth_e, drive_chk;
  logic signed [PW-1:0] drive_p, target_p, d10, t9, t11;
  logic [DS-1:0] tenth_x, tenth_q0, tenth_r;
  logic [DS+DS-1:0] tenth_prod;
  logic [VW-1:0] tenth;
  logic [FS-1:0] fifth_q0, fifth_r;
  logic [FS+FS-1:0] fifth_prod;
  logic [STEP_WIDTH-1:0] fifth;
  logic err_small, win_out, bad_sign;
  logic [VW-1:0] dn_slow, dn_fifth, up_fast, up_slow, up_fifth;
  logic abort;

  assign drive_e = EW'($signed(st.drive));
  assign target_e = EW'($signed(st.target));
  assign fb_e = $signed({{(EW - KV_WIDTH){1'b0}}, item.feedback});
  assign min_e = $signed({{(EW - KV_WIDTH){1'b0}}, cfg.min_kv});
  assign max_e = $signed({{(EW - KV_WIDTH){1'b0}}, cfg.max_kv});
  assign slow_e = $signed({{(EW - STEP_WIDTH){1'b0}}, cfg.slow_step});
  assign fast_e = $signed({{(EW - STEP_WIDTH){1'b0}}, cfg.fast_step});
  assign err = fb_e - target_e;
  assign err_small = (err < ERR_STABLE) && (err > -ERR_STABLE);
  assign bad_sign = drive_e[EW-1] || target_e[EW-1];

  // drive window 0.9 .. 1.1 of target
  assign drive_p = PW'($signed(st.drive));
  assign target_p = PW'($signed(st.target));
  assign d10 = drive_p * TEN;
  assign t9 = target_p * NINE;
  assign t11 = target_p * ELEVEN;
  assign win_out = (d10 > t11) || (d10 < t9);

  // 0.9 of target, only used when target is known non-negative
  assign tenth_x = DS'(t9);
  assign tenth_prod = {{DS{1'b0}}, tenth_x} * (DS + DS)'(DM);
  assign tenth_q0 = tenth_prod[DS+DS-1:DS];
  assign tenth_r = tenth_x - DS'(tenth_q0 * DS'(10));
  assign tenth = (tenth_r >= DS'(10)) ? VW'(tenth_q0 + DS'(1)) : VW'(tenth_q0);

  // fifth of the slow step
  assign fifth_prod = {{(FS + FS - STEP_WIDTH){1'b0}}, cfg.slow_step} * (FS + FS)'(FM);
  assign fifth_q0 = fifth_prod[FS+FS-1:FS];
  assign fifth_r = FS'(cfg.slow_step) - FS'(fifth_q0 * FS'(5));
  assign fifth = (fifth_r >= FS'(5)) ? STEP_WIDTH'(fifth_q0 + FS'(1)) : STEP_WIDTH'(fifth_q0);
  assign fifth_e = $signed({{(EW - STEP_WIDTH){1'b0}}, fifth});

  assign dn_slow = sat_value(drive_e - slow_e);
  assign dn_fifth = sat_value(drive_e - fifth_e);
  assign up_fast = sat_value(drive_e + fast_e);
  assign up_slow = sat_value(drive_e + slow_e);
  assign up_fifth = sat_value(drive_e + fifth_e);

  always_comb begin
    st_next = st;
    abort = 1'b0;
    drive_chk = drive_e;
    if (item.op == OP_SET) begin
      st_next.stable_count = 2'd0;
      if (item.hv_enabled) begin
        st_next.ramp = 1'b1;
        st_next.target = item.setpoint;
      end else begin
        st_next.target = '0;
        st_next.drive = '0;
        abort = 1'b1;
      end
    end else if (st.ramp) begin
      if (bad_sign || (target_e < min_e)) begin
        st_next.drive = '0;
        st_next.target = '0;
        st_next.ramp = 1'b0;
        abort = 1'b1;
      end else if (err_small) begin
        if (st.stable_count == 2'd3) begin
          st_next.stable_count = 2'd0;
          st_next.ramp = 1'b0;
          if (win_out) begin
            st_next.drive = '0;
            st_next.target = '0;
            abort = 1'b1;
          end
        end else begin
          st_next.stable_count = st.stable_count + 2'd1;
        end
      end else begin
        st_next.stable_count = 2'd0;
        if (err > ERR_DROP) st_next.drive = tenth;
        else if (err > ERR_STABLE) st_next.drive = dn_slow;
        else if (err > ERR_FINE) st_next.drive = dn_fifth;
        else if (err < -ERR_FAST) st_next.drive = up_fast;
        else if (err < -ERR_STABLE) st_next.drive = up_slow;
        else if (err < -ERR_FINE) st_next.drive = up_fifth;
      end
      // over-voltage limit applies to whatever drive came out of the step
      drive_chk = EW'($signed(st_next.drive));
      if (drive_chk >= max_e) begin
        st_next.drive = '0;
        st_next.target = '0;
        st_next.ramp = 1'b0;
        abort = 1'b1;
      end
    end
  end

  assign res.drive = st_next.drive;
  assign res.ramping = st_next.ramp;
  assign res.aborted = abort;

endmodule

/* sv/kv_setpoint_ramp_controller.sv */
// top level of the kv setpoint ramp controller: item register, state, result register
//
// Takes one transaction per clock while in_stall is low and returns exactly one
// result for each. A transaction is captured in an item register; once the
// result register is free or being drained, the combinational step logic updates
// drive, target, ramp flag and stable count and loads the result register.
// in_stall rises only while a result is held under out_stall and another
// transaction waits in the item register.
// Configuration writes are always ready and should be made while idle.
module kv_setpoint_ramp_controller (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic op,
  input  logic hv_enabled,
  input  logic signed [kvr_pkg::VALUE_WIDTH-1:0] setpoint_kv,
  input  logic [kvr_pkg::KV_WIDTH-1:0] kv_feedback,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [kvr_pkg::VALUE_WIDTH-1:0] kv_drive,
  output logic ramping,
  output logic aborted,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [kvr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [kvr_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
  import kvr_pkg::*;

  kvr_cfg_t cfg;
  kvr_state_t st, st_next;
  kvr_item_t item;
  kvr_result_t res, result;
  logic item_valid;
  logic advance;

  assign cfg_ready = 1'b1;

  kvr_cfg_regs u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg)
  );

  kvr_step u_step (
    .cfg(cfg),
    .st(st),
    .item(item),
    .st_next(st_next),
    .res(res)
  );

  assign advance = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.op <= op;
      item.hv_enabled <= hv_enabled;
      item.setpoint <= setpoint_kv;
      item.feedback <= kv_feedback;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

  assign kv_drive = $signed(result.drive);
  assign ramping = result.ramping;
  assign aborted = result.aborted;

  // a shown result always mirrors the live state until the next transaction
  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result.drive == st.drive) && (result.ramping == st.ramp))
    else $error("result register out of step with state");

  a_abort_zeroes_drive: assert property (@(posedge clk) disable iff (rst)
    (advance && res.aborted) |=> (st.drive == '0) && (st.target == '0))
    else $error("abort left drive or target nonzero");

  a_idle_tick_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (advance && (item.op == OP_TICK) && !st.ramp) |=> $stable(st))
    else $error("tick while not ramping changed state");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !advance) |=> item_valid && $stable(item))
    else $error("waiting transaction lost");

endmodule
